@@ hdl/nts_pkg.sv @@
// Package for the navigation type signature scanner.
// Holds the signature table, field widths, register map constants and the
// event tag type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nts_pkg;

    localparam int BYTE_W     = 8;
    localparam int WINDOW_W   = 32;
    localparam int INDEX_W    = 5;
    localparam int FILL_W     = 3;
    localparam int NUM_SIGS   = 19;
    localparam int START_OFS_W = 24;

    // The window holds four bytes once it is full.
    localparam logic [FILL_W-1:0] FILL_FULL = 3'd4;

    // APB register map: one 32-bit register per word.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_START_OFFSET = 1'b0;

    // Four-character type names, first character in the top byte.
    localparam logic [WINDOW_W-1:0] SIG_TABLE [NUM_SIGS] = '{
        32'h41495243, 32'h444D5350, 32'h474D5358, 32'h474F4553, 32'h47524146,
        32'h47564152, 32'h4C414C4F, 32'h4C414D42, 32'h4D455243, 32'h4D4F4C4C,
        32'h4D534154, 32'h4D534720, 32'h4E4F5752, 32'h50532020, 32'h52414452,
        32'h52454354, 32'h53494E20, 32'h54414E43, 32'h5449524F
    };

    // Classification of one finished scan, handed from front to back.
    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] type_index;
    } nts_tag_t;

endpackage

`default_nettype wire

@@ hdl/nts_ifs.sv @@
// Channel interfaces for the signature scanner: the byte stream and the result.
// Depends on nts_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface nts_byte_if;
    import nts_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              restart;
    logic              last_byte;

    modport source (output valid, output data_byte, output restart, output last_byte,
                    input ready);
    modport sink   (input valid, input data_byte, input restart, input last_byte,
                    output ready);
endinterface

interface nts_result_if #(parameter int OFFSET_BITS = 24);
    import nts_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   found;
    logic [INDEX_W-1:0]     type_index;
    logic [OFFSET_BITS-1:0] match_offset;

    modport source (output valid, output found, output type_index, output match_offset,
                    input ready);
    modport sink   (input valid, input found, input type_index, input match_offset,
                    output ready);
endinterface

`default_nettype wire

@@ hdl/nts_front.sv @@
// Front end of the scanner: takes bytes, keeps the window and scan position,
// and classifies each byte. Depends on nts_pkg and nts_byte_if.
`timescale 1ns / 1ps
`default_nettype none

module nts_front #(
    parameter int OFFSET_BITS = 24
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    nts_byte_if.sink                    in_ch,
    input  wire logic                   push_ready,
    output logic                        push_valid,
    output nts_pkg::nts_tag_t           push_tag,
    output logic [OFFSET_BITS-1:0]      push_first
);
    import nts_pkg::*;

    localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};
    localparam logic [OFFSET_BITS-1:0] LEAD    = OFFSET_BITS'(3);

    logic [WINDOW_W-1:0]    window_reg, window_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic                   done_reg;

    logic [WINDOW_W-1:0]    window_eff;
    logic [FILL_W-1:0]      fill_eff;
    logic [OFFSET_BITS-1:0] pos_eff;
    logic                   done_eff;
    logic                   accept;
    logic                   hit;
    logic [INDEX_W-1:0]     hit_idx;
    logic                   match;

    assign in_ch.ready = push_ready;
    assign accept      = in_ch.valid && in_ch.ready;

    // A restart clears the scan before the byte itself is taken in.
    always_comb
    begin
        window_eff = in_ch.restart ? '0 : window_reg;
        fill_eff   = in_ch.restart ? '0 : fill_reg;
        pos_eff    = in_ch.restart ? '0 : pos_reg;
        done_eff   = in_ch.restart ? 1'b0 : done_reg;

        window_next = {window_eff[WINDOW_W-BYTE_W-1:0], in_ch.data_byte};
        fill_next   = (fill_eff == FILL_FULL) ? fill_eff : fill_eff + FILL_W'(1);
        pos_next    = (pos_eff == POS_MAX) ? pos_eff : pos_eff + OFFSET_BITS'(1);
    end

    // Parallel compare against every name; the lowest index wins.
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = NUM_SIGS - 1; i >= 0; i--)
        begin
            if (window_next == SIG_TABLE[i])
            begin
                hit     = 1'b1;
                hit_idx = INDEX_W'(i);
            end
        end
    end

    assign match = hit && (fill_next == FILL_FULL);

    always_comb
    begin
        push_valid          = accept && !done_eff && (match || in_ch.last_byte);
        push_tag.found      = match;
        push_tag.type_index = match ? hit_idx : '0;
        if (!match)
            push_first = '0;
        else if (pos_eff >= LEAD)
            push_first = pos_eff - LEAD;
        else
            push_first = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            fill_reg   <= '0;
            pos_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else if (accept && !done_eff)
        begin
            window_reg <= window_next;
            fill_reg   <= fill_next;
            pos_reg    <= pos_next;
            done_reg   <= match || in_ch.last_byte;
        end
    end

    // The queue must have room whenever a result is produced.
    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> push_ready)
        else $error("front pushed into a full queue");

    // Every reported result closes the scan until a restart.
    a_push_closes_scan: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |=> done_reg)
        else $error("scan not closed after a result");

    // A match is only reported once four bytes are in the window.
    a_match_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && push_tag.found) |-> (fill_next == FILL_FULL))
        else $error("match reported with a partial window");

endmodule

`default_nettype wire

@@ hdl/nts_queue.sv @@
// Two-entry queue that decouples the scanner front end from the back end.
// Depends on nts_pkg for the event tag type.
`timescale 1ns / 1ps
`default_nettype none

module nts_queue #(
    parameter int OFFSET_BITS = 24
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push_valid,
    output logic                        push_ready,
    input  wire nts_pkg::nts_tag_t      push_tag,
    input  wire logic [OFFSET_BITS-1:0] push_first,
    output logic                        pop_valid,
    input  wire logic                   pop_ready,
    output nts_pkg::nts_tag_t           pop_tag,
    output logic [OFFSET_BITS-1:0]      pop_first
);
    import nts_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = 1;
    localparam int CNT_W = 2;

    nts_tag_t               tag_q   [DEPTH];
    logic [OFFSET_BITS-1:0] first_q [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_tag    = tag_q[rd_ptr_reg];
    assign pop_first  = first_q[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            tag_q[wr_ptr_reg]   <= push_tag;
            first_q[wr_ptr_reg] <= push_first;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/nts_back.sv @@
// Back end of the scanner: forms the reported offset and holds the result
// register. Depends on nts_pkg and nts_result_if.
`timescale 1ns / 1ps
`default_nettype none

module nts_back #(
    parameter int OFFSET_BITS = 24
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [nts_pkg::START_OFS_W-1:0] start_offset,
    input  wire logic                           pop_valid,
    output logic                                pop_ready,
    input  wire nts_pkg::nts_tag_t              pop_tag,
    input  wire logic [OFFSET_BITS-1:0]         pop_first,
    nts_result_if.source                        out_ch
);
    import nts_pkg::*;

    localparam int SUM_W = ((OFFSET_BITS > START_OFS_W) ? OFFSET_BITS : START_OFS_W) + 1;
    localparam logic [SUM_W-1:0] OFS_MAX =
        {{(SUM_W - OFFSET_BITS){1'b0}}, {OFFSET_BITS{1'b1}}};

    logic                   valid_reg;
    logic                   found_reg;
    logic [INDEX_W-1:0]     index_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic [SUM_W-1:0]       sum;
    logic [OFFSET_BITS-1:0] offset_next;
    logic                   load;

    assign pop_ready = !valid_reg || out_ch.ready;
    assign load      = pop_valid && pop_ready;

    // The offset saturates at the top of the offset range.
    always_comb
    begin
        sum = SUM_W'(start_offset) + SUM_W'(pop_first);
        if (!pop_tag.found)
            offset_next = '0;
        else if (sum > OFS_MAX)
            offset_next = OFS_MAX[OFFSET_BITS-1:0];
        else
            offset_next = sum[OFFSET_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop_ready)
            valid_reg <= pop_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            found_reg  <= pop_tag.found;
            index_reg  <= pop_tag.type_index;
            offset_reg <= offset_next;
        end
    end

    assign out_ch.valid        = valid_reg;
    assign out_ch.found        = found_reg;
    assign out_ch.type_index   = index_reg;
    assign out_ch.match_offset = offset_reg;

    // A not-found result carries zero index and zero offset.
    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.found) |->
            (out_ch.type_index == '0 && out_ch.match_offset == '0))
        else $error("not-found result with nonzero payload");

endmodule

`default_nettype wire

@@ hdl/nav_type_signature_scanner_core.sv @@
// Navigation type signature scanner, top level. Takes a byte stream one byte
// per cycle while the queue has room and looks for one of 19 four-character
// navigation type names in the last four bytes. Once a name matches, a single
// found request carries the name's index and the offset of its first byte
// (start_offset plus the scan position, saturating at 2^OFFSET_BITS-1); if the
// stream ends with no match a single not-found request is given instead. After
// either, bytes are ignored until one arrives with restart set, which clears
// the scan before that byte is taken in. The block sustains one byte per clock
// while the queue has room: the window shift and the 19 parallel compares are
// combinational in the front end. A result passes through the two-entry queue
// and then the output register before it is offered on the output channel.
// The queue and the output register absorb output stalls, so bytes keep
// flowing while fewer than three results are pending. The start_offset
// register sits at APB address 0 and should only be written while no scan
// result is pending. Depends on nts_pkg and nts_ifs.
`timescale 1ns / 1ps
`default_nettype none

module nav_type_signature_scanner_core #(
    parameter int OFFSET_BITS = 24
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [nts_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [nts_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [nts_pkg::APB_DATA_W-1:0] prdata,
    output logic                               pready,
    nts_byte_if.sink                           in_ch,
    nts_result_if.source                       out_ch
);
    import nts_pkg::*;

    logic [START_OFS_W-1:0] start_offset_reg;
    logic                   reg_sel;
    logic                   reg_write;

    logic                   push_valid, push_ready;
    nts_tag_t               push_tag;
    logic [OFFSET_BITS-1:0] push_first;
    logic                   pop_valid, pop_ready;
    nts_tag_t               pop_tag;
    logic [OFFSET_BITS-1:0] pop_first;

    // Register access: the word index is the address above the byte lanes.
    assign pready    = 1'b1;
    assign reg_sel   = (paddr[APB_ADDR_W-1:2] == REG_START_OFFSET);
    assign reg_write = psel && penable && pwrite && pready && reg_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_offset_reg <= '0;
        else if (reg_write)
            start_offset_reg <= pwdata[START_OFS_W-1:0];
    end

    always_comb
    begin
        if (reg_sel)
            prdata = APB_DATA_W'(start_offset_reg);
        else
            prdata = '0;
    end

    // Front end: window, position and classification of each byte.
    nts_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_tag   (push_tag),
        .push_first (push_first)
    );

    // Short queue so the front keeps taking bytes while the output stalls.
    nts_queue #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_tag   (push_tag),
        .push_first (push_first),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_tag    (pop_tag),
        .pop_first  (pop_first)
    );

    // Back end: offset arithmetic and the output register.
    nts_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .start_offset (start_offset_reg),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_tag      (pop_tag),
        .pop_first    (pop_first),
        .out_ch       (out_ch)
    );

endmodule

`default_nettype wire
